/* sv/pfa_pkg.sv */
`default_nettype none
package pfa_pkg;

  localparam int NUM_PARTS = 16;
  localparam int IDX_W = (NUM_PARTS > 1) ? $clog2(NUM_PARTS) : 1;
  localparam int BC_W = 5;
  localparam int KIND_W = 3;
  localparam int ID_W = 16;
  localparam int SIZE_W = 16;
  localparam int LIDX_W = 4;
  localparam int STAT_W = 3;
  localparam int OUT_IDX_W = 4;
  localparam int CMP_W = BC_W + IDX_W;

  localparam logic [BC_W-1:0] BLOCK_COUNT_RESET = BC_W'(16);

  localparam logic [KIND_W-1:0] KIND_LOAD = 3'd0;
  localparam logic [KIND_W-1:0] KIND_FIRST = 3'd1;
  localparam logic [KIND_W-1:0] KIND_BEST = 3'd2;
  localparam logic [KIND_W-1:0] KIND_WORST = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 3'd4;

  localparam logic [STAT_W-1:0] ST_ALLOC = 3'd0;
  localparam logic [STAT_W-1:0] ST_FAIL = 3'd1;
  localparam logic [STAT_W-1:0] ST_RELEASED = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOTFOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_LOADED = 3'd4;

  localparam logic [1:0] CMD_LOAD = 2'd0;
  localparam logic [1:0] CMD_ALLOC = 2'd1;
  localparam logic [1:0] CMD_RELEASE = 2'd2;

  typedef struct packed {
    logic valid;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0] owner;
    logic [SIZE_W-1:0] need;
    logic found;
    logic [IDX_W-1:0] sel_idx;
    logic [SIZE_W-1:0] sel_size;
  } probe_t;

  typedef struct packed {
    logic we;
    logic [1:0] op;
    logic [IDX_W-1:0] idx;
    logic [SIZE_W-1:0] size;
    logic [ID_W-1:0] owner;
  } cmd_t;

endpackage
`default_nettype wire

/* sv/pfa_cell.sv */
`default_nettype none
module pfa_cell
  import pfa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic [IDX_W-1:0] cell_idx,
  input  wire logic [BC_W-1:0] block_count,
  input  wire probe_t probe_in,
  input  wire cmd_t cmd,
  output probe_t probe_out
);

  logic [SIZE_W-1:0] size;
  logic free;
  logic taken;
  logic [ID_W-1:0] owner;
  logic in_range;
  logic fit;
  logic take;
  probe_t probe_next;

  assign in_range = CMP_W'(cell_idx) < CMP_W'(block_count);
  assign fit = free && (size >= probe_in.need);

  always_comb begin
    case (probe_in.kind)
      KIND_FIRST:   take = fit && !probe_in.found;
      KIND_BEST:    take = fit && (!probe_in.found || size < probe_in.sel_size);
      KIND_WORST:   take = fit && (!probe_in.found || size > probe_in.sel_size);
      KIND_RELEASE: take = taken && (owner == probe_in.owner) && !probe_in.found;
      default:      take = 1'b0;
    endcase
    probe_next = probe_in;
    if (probe_in.valid && in_range && take) begin
      probe_next.found = 1'b1;
      probe_next.sel_idx = cell_idx;
      probe_next.sel_size = size;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      probe_out.valid <= 1'b0;
    end else begin
      probe_out.valid <= probe_next.valid;
    end
    probe_out.kind <= probe_next.kind;
    probe_out.owner <= probe_next.owner;
    probe_out.need <= probe_next.need;
    probe_out.found <= probe_next.found;
    probe_out.sel_idx <= probe_next.sel_idx;
    probe_out.sel_size <= probe_next.sel_size;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free <= 1'b0;
      taken <= 1'b0;
      owner <= '0;
    end else if (cmd.we && cmd.idx == cell_idx) begin
      case (cmd.op)
        CMD_LOAD: begin
          free <= 1'b1;
          taken <= 1'b0;
          owner <= '0;
        end
        CMD_ALLOC: begin
          free <= 1'b0;
          taken <= 1'b1;
          owner <= cmd.owner;
        end
        CMD_RELEASE: begin
          free <= 1'b1;
          taken <= 1'b0;
          owner <= '0;
        end
        default: begin
          free <= free;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.we && cmd.idx == cell_idx && cmd.op == CMD_LOAD) begin
      size <= cmd.size;
    end
  end

endmodule
`default_nettype wire

/* sv/partition_fit_allocator.sv */
// Channel   Handshake          Payload
// config    cfg_we             cfg_wdata (block_count)
// request   start, busy        kind, owner_id, request_size, load_index
// result    done               status, chosen_index
//
// A load or an unknown kind is applied at the accepting edge and its result
// appears in the next cycle, with busy staying low.
// An allocate or release sends a probe down the row of 16 partition cells,
// one cell per cycle, and its result is registered once the probe leaves the last cell.
// busy is high while a probe is in the row; the result cycle can accept a new item.
// Reset clears every partition to unavailable and block_count to 16.
// The receiver cannot stall: each result holds for one cycle only.
`default_nettype none
module partition_fit_allocator
  import pfa_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic cfg_we,
  input  wire logic [BC_W-1:0] cfg_wdata,
  input  wire logic start,
  output logic busy,
  input  wire logic [KIND_W-1:0] kind,
  input  wire logic [ID_W-1:0] owner_id,
  input  wire logic [SIZE_W-1:0] request_size,
  input  wire logic [LIDX_W-1:0] load_index,
  output logic done,
  output logic [STAT_W-1:0] status,
  output logic [OUT_IDX_W-1:0] chosen_index
);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t state;
  logic [BC_W-1:0] block_count;
  probe_t chain [0:NUM_PARTS];
  logic [NUM_PARTS:0] chain_valid;
  cmd_t cmd;
  logic accept;
  logic is_scan;
  logic load_ok;
  probe_t probe_head;
  probe_t probe_end;

  assign busy = (state == S_SCAN);
  assign accept = start && !busy;
  assign is_scan = (kind == KIND_FIRST) || (kind == KIND_BEST) ||
                   (kind == KIND_WORST) || (kind == KIND_RELEASE);
  assign load_ok = (kind == KIND_LOAD) && (int'(load_index) < NUM_PARTS);
  assign chain[0] = probe_head;
  assign probe_end = chain[NUM_PARTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_we) begin
      block_count <= cfg_wdata;
    end
  end

  always_comb begin
    probe_head.valid = accept && is_scan;
    probe_head.kind = kind;
    probe_head.owner = owner_id;
    probe_head.need = request_size;
    probe_head.found = 1'b0;
    probe_head.sel_idx = '0;
    probe_head.sel_size = '0;
  end

  always_comb begin
    cmd.we = 1'b0;
    cmd.op = CMD_LOAD;
    cmd.idx = IDX_W'(load_index);
    cmd.size = request_size;
    cmd.owner = owner_id;
    if (probe_end.valid && probe_end.found) begin
      cmd.we = 1'b1;
      cmd.op = (probe_end.kind == KIND_RELEASE) ? CMD_RELEASE : CMD_ALLOC;
      cmd.idx = probe_end.sel_idx;
      cmd.owner = probe_end.owner;
    end else if (accept && load_ok) begin
      cmd.we = 1'b1;
    end
  end

  for (genvar i = 0; i < NUM_PARTS; i++) begin : g_cell
    pfa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .cell_idx   (IDX_W'(i)),
      .block_count(block_count),
      .probe_in   (chain[i]),
      .cmd        (cmd),
      .probe_out  (chain[i+1])
    );
  end

  for (genvar i = 0; i <= NUM_PARTS; i++) begin : g_vld
    assign chain_valid[i] = chain[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done <= 1'b0;
      status <= ST_FAIL;
      chosen_index <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (is_scan) begin
              state <= S_SCAN;
            end else begin
              done <= 1'b1;
              status <= load_ok ? ST_LOADED : ST_FAIL;
              chosen_index <= load_ok ? OUT_IDX_W'(load_index) : '0;
            end
          end
        end
        S_SCAN: begin
          if (probe_end.valid) begin
            state <= S_IDLE;
            done <= 1'b1;
            chosen_index <= probe_end.found ? OUT_IDX_W'(probe_end.sel_idx) : '0;
            if (probe_end.kind == KIND_RELEASE) begin
              status <= probe_end.found ? ST_RELEASED : ST_NOTFOUND;
            end else begin
              status <= probe_end.found ? ST_ALLOC : ST_FAIL;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_one_probe: assert property (@(posedge clk) disable iff (rst)
    $countones(chain_valid[NUM_PARTS:1]) <= 1)
    else $error("More than one probe in the cell row.");

  a_probe_in_scan: assert property (@(posedge clk) disable iff (rst)
    |chain_valid[NUM_PARTS:1] |-> state == S_SCAN)
    else $error("Probe in the cell row while idle.");

  a_transfer_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> done || busy)
    else $error("Accepted transfer produced neither a result nor a scan.");

  a_done_status: assert property (@(posedge clk) disable iff (rst)
    done && (status == ST_FAIL || status == ST_NOTFOUND) |-> chosen_index == '0)
    else $error("Nonzero index on a failed result.");

endmodule
`default_nettype wire
